// ===== hdl/sacc_pkg.sv =====
// ----------------------------------------------------------------------------
// sacc_pkg
// Shared types and constants of the servo arm command controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sacc_pkg;

   localparam int unsigned SERVOS = 4;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] byte_value;
      logic [1:0] channel;
   } req_type;

   typedef struct packed {
      logic [7:0] base_position;
      logic [7:0] gripper_position;
      logic [7:0] elbow_position;
      logic [7:0] arm_position;
      logic [1:0] mode_now;
      logic       enabled_now;
      logic       playing_now;
      logic [2:0] selected_now;
   } rsp_type;

   typedef logic [SERVOS-1:0][7:0] pos_array_type;

   // event codes
   localparam logic [2:0] CMD_MODE   = 3'd0;
   localparam logic [2:0] CMD_ENABLE = 3'd1;
   localparam logic [2:0] CMD_BTN_A  = 3'd2;
   localparam logic [2:0] CMD_BTN_B  = 3'd3;
   localparam logic [2:0] CMD_BTN_C  = 3'd4;
   localparam logic [2:0] CMD_SERIAL = 3'd5;
   localparam logic [2:0] CMD_SAMPLE = 3'd6;

   // operating modes
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_SERIAL = 2'd2;
   localparam logic [1:0] MODE_REMOTE = 2'd3;

   // serial byte codes
   localparam logic [7:0] SER_LOW_PRESET  = 8'd0;
   localparam logic [7:0] SER_HIGH_PRESET = 8'd5;
   localparam logic [7:0] SER_SEL_FIRST   = 8'd1;
   localparam logic [7:0] SER_SEL_LAST    = 8'd4;
   localparam logic [7:0] SER_PLAY_STOP   = 8'd0;
   localparam logic [7:0] SER_PLAY_START  = 8'd255;

   localparam logic [2:0] SEL_NONE = 3'd0;
   localparam logic [2:0] SEL_MAX  = 3'd4;

   // element order: arm, elbow, gripper, base
   localparam pos_array_type PRESET_LOW   = {8'd25, 8'd20, 8'd20, 8'd25};
   localparam pos_array_type PRESET_HIGH  = {8'd60, 8'd80, 8'd42, 8'd60};
   localparam pos_array_type RANGE_LO_INIT = {8'd25, 8'd20, 8'd30, 8'd30};
   localparam pos_array_type RANGE_HI_INIT = {8'd60, 8'd80, 8'd43, 8'd60};

   localparam logic [7:0] TOGGLE_A_ON  = 8'd60;
   localparam logic [7:0] TOGGLE_A_OFF = 8'd25;
   localparam logic [7:0] GRIP_B_ON    = 8'd42;
   localparam logic [7:0] ELBOW_B_ON   = 8'd80;
   localparam logic [7:0] TOGGLE_B_OFF = 8'd20;
   localparam logic [7:0] SERIAL_ENTRY = 8'd20;

endpackage

`default_nettype wire

// ===== hdl/sacc_scale.sv =====
// ----------------------------------------------------------------------------
// sacc_scale
// Maps a byte into a servo range: low + (byte * span) / 255, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module sacc_scale (
   input  wire logic [7:0] lo,
   input  wire logic [7:0] hi,
   input  wire logic [7:0] value,
   output logic      [7:0] scaled
);

   logic [7:0]  span;
   logic [15:0] prod;
   logic [15:0] adj;

   always_comb begin
      span = (hi >= lo) ? (hi - lo) : 8'd0;
      prod = {8'd0, value} * {8'd0, span};
      // exact divide by 255 for products up to 255*255
      adj = prod + {8'd0, prod[15:8]} + 16'd1;
      scaled = lo + adj[15:8];
   end

endmodule

`default_nettype wire

// ===== hdl/sacc_core.sv =====
// ----------------------------------------------------------------------------
// sacc_core
// Mode, enable and position state with the per-event update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sacc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire sacc_pkg::req_type      item,
   input  wire sacc_pkg::pos_array_type range_lo,
   input  wire sacc_pkg::pos_array_type range_hi,
   output sacc_pkg::rsp_type           result
);

   logic [1:0] mode_ff, mode_in;
   logic       enable_ff, enable_in;
   logic       playing_ff, playing_in;
   logic [2:0] selected_ff, selected_in;
   logic       toggle_a_ff, toggle_a_in;
   logic       toggle_b_ff, toggle_b_in;
   sacc_pkg::pos_array_type pos_ff, pos_in;
   sacc_pkg::pos_array_type saved_ff, saved_in;
   sacc_pkg::pos_array_type pot_ff, pot_in;

   sacc_pkg::pos_array_type lane_in;
   sacc_pkg::pos_array_type lane_out;

   logic       entry_cmd;
   logic       remote;
   logic       sel_valid;
   logic [1:0] sel_idx;
   logic       is_select;

   // lanes rescale the stored samples on mode entry, else the event byte
   assign entry_cmd = (item.command == sacc_pkg::CMD_MODE) ||
                      (item.command == sacc_pkg::CMD_ENABLE);

   for (genvar i = 0; i < sacc_pkg::SERVOS; i++) begin : g_lane
      assign lane_in[i] = entry_cmd ? pot_ff[i] : item.byte_value;
      sacc_scale u_scale (
         .lo     (range_lo[i]),
         .hi     (range_hi[i]),
         .value  (lane_in[i]),
         .scaled (lane_out[i])
      );
   end

   always_comb begin
      mode_in     = mode_ff;
      enable_in   = enable_ff;
      playing_in  = playing_ff;
      selected_in = selected_ff;
      toggle_a_in = toggle_a_ff;
      toggle_b_in = toggle_b_ff;
      pos_in      = pos_ff;
      saved_in    = saved_ff;
      pot_in      = pot_ff;

      remote    = (mode_ff == sacc_pkg::MODE_REMOTE);
      sel_valid = (selected_ff != sacc_pkg::SEL_NONE) && (selected_ff <= sacc_pkg::SEL_MAX);
      sel_idx   = 2'(selected_ff - 3'd1);
      is_select = (item.byte_value >= sacc_pkg::SER_SEL_FIRST) &&
                  (item.byte_value <= sacc_pkg::SER_SEL_LAST);

      case (item.command)
         sacc_pkg::CMD_MODE: begin
            mode_in = mode_ff + 2'd1;
         end
         sacc_pkg::CMD_ENABLE: begin
            enable_in = !enable_ff;
            if (enable_ff) begin
               playing_in = 1'b0;
            end
         end
         sacc_pkg::CMD_BTN_A: begin
            if (enable_ff && mode_ff == sacc_pkg::MODE_AUTO) begin
               toggle_a_in = !toggle_a_ff;
               pos_in[0] = !toggle_a_ff ? sacc_pkg::TOGGLE_A_ON : sacc_pkg::TOGGLE_A_OFF;
               pos_in[3] = !toggle_a_ff ? sacc_pkg::TOGGLE_A_ON : sacc_pkg::TOGGLE_A_OFF;
            end
         end
         sacc_pkg::CMD_BTN_B: begin
            if (enable_ff && mode_ff == sacc_pkg::MODE_AUTO) begin
               toggle_b_in = !toggle_b_ff;
               pos_in[1] = !toggle_b_ff ? sacc_pkg::GRIP_B_ON : sacc_pkg::TOGGLE_B_OFF;
               pos_in[2] = !toggle_b_ff ? sacc_pkg::ELBOW_B_ON : sacc_pkg::TOGGLE_B_OFF;
            end
         end
         sacc_pkg::CMD_BTN_C: begin
            if (enable_ff && mode_ff == sacc_pkg::MODE_AUTO) begin
               pos_in = saved_ff;
            end else if (enable_ff && mode_ff == sacc_pkg::MODE_MANUAL) begin
               saved_in = pos_ff;
            end
         end
         sacc_pkg::CMD_SERIAL: begin
            if (enable_ff && !playing_ff &&
                (mode_ff == sacc_pkg::MODE_SERIAL || remote)) begin
               if (is_select) begin
                  selected_in = item.byte_value[2:0];
               end else if (remote && item.byte_value == sacc_pkg::SER_PLAY_STOP) begin
                  playing_in = 1'b0;
               end else if (remote && item.byte_value == sacc_pkg::SER_PLAY_START) begin
                  playing_in = 1'b1;
               end else if (sel_valid) begin
                  if (!remote && item.byte_value == sacc_pkg::SER_LOW_PRESET) begin
                     pos_in[sel_idx] = sacc_pkg::PRESET_LOW[sel_idx];
                  end else if (!remote && item.byte_value == sacc_pkg::SER_HIGH_PRESET) begin
                     pos_in[sel_idx] = sacc_pkg::PRESET_HIGH[sel_idx];
                  end else begin
                     pos_in[sel_idx] = lane_out[sel_idx];
                  end
               end
            end
         end
         sacc_pkg::CMD_SAMPLE: begin
            if (enable_ff && mode_ff == sacc_pkg::MODE_MANUAL) begin
               pot_in[item.channel] = item.byte_value;
               pos_in[item.channel] = lane_out[item.channel];
            end
         end
         default: begin
         end
      endcase

      // mode entry action, only reachable from mode and enable events
      if (enable_in && (!enable_ff || mode_in != mode_ff)) begin
         case (mode_in)
            sacc_pkg::MODE_AUTO: begin
               pos_in = saved_ff;
            end
            sacc_pkg::MODE_MANUAL: begin
               pos_in = lane_out;
            end
            sacc_pkg::MODE_SERIAL: begin
               pos_in = {sacc_pkg::SERVOS{sacc_pkg::SERIAL_ENTRY}};
            end
            default: begin
            end
         endcase
      end

      result.base_position    = pos_in[0];
      result.gripper_position = pos_in[1];
      result.elbow_position   = pos_in[2];
      result.arm_position     = pos_in[3];
      result.mode_now         = mode_in;
      result.enabled_now      = enable_in;
      result.playing_now      = playing_in;
      result.selected_now     = selected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sacc_pkg::MODE_AUTO;
         enable_ff   <= 1'b0;
         playing_ff  <= 1'b0;
         selected_ff <= sacc_pkg::SEL_NONE;
         toggle_a_ff <= 1'b0;
         toggle_b_ff <= 1'b0;
         pos_ff      <= '0;
         saved_ff    <= '0;
         pot_ff      <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         enable_ff   <= enable_in;
         playing_ff  <= playing_in;
         selected_ff <= selected_in;
         toggle_a_ff <= toggle_a_in;
         toggle_b_ff <= toggle_b_in;
         pos_ff      <= pos_in;
         saved_ff    <= saved_in;
         pot_ff      <= pot_in;
      end
   end

   a_play_needs_enable: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> enable_ff)
      else $error("playback active while disabled");

   a_selected_range: assert property (@(posedge clock) disable iff (reset)
      selected_ff <= sacc_pkg::SEL_MAX)
      else $error("selected servo out of range");

   a_disable_stops_play: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == sacc_pkg::CMD_ENABLE && enable_ff |=> !enable_ff && !playing_ff)
      else $error("disable did not stop playback");

   a_mode_only_on_button: assert property (@(posedge clock) disable iff (reset)
      !(fire && item.command == sacc_pkg::CMD_MODE) |=> $stable(mode_ff))
      else $error("mode changed without a mode button event");

endmodule

`default_nettype wire

// ===== hdl/servo_arm_command_controller.sv =====
// ----------------------------------------------------------------------------
// servo_arm_command_controller
// Event driven servo arm controller: input register, update logic, result
// register and the range configuration registers.
// ----------------------------------------------------------------------------
// path: an accepted event waits in the input register, runs through the update
//   logic and lands in the result register; a response stall holds both registers
// throughput: one event per cycle while the response side does not stall
// reset: synchronous; clears mode, flags, positions, saved positions and
//   samples, and loads the default servo ranges
`default_nettype none

module servo_arm_command_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sacc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sacc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [4:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic                    in_vld_ff, in_vld_in;
   sacc_pkg::req_type       in_data_ff, in_data_in;
   logic                    out_vld_ff, out_vld_in;
   sacc_pkg::rsp_type       out_data_ff, out_data_in;
   sacc_pkg::pos_array_type range_lo_ff, range_lo_in;
   sacc_pkg::pos_array_type range_hi_ff, range_hi_in;

   logic              accept;
   logic              fire;
   logic              csr_write;
   logic [1:0]        csr_servo;
   sacc_pkg::rsp_type core_result;

   assign fire      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_servo  = csr_paddr[4:3];

   always_comb begin
      in_vld_in   = accept ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
      in_data_in  = accept ? req_data : in_data_ff;
      out_vld_in  = fire ? 1'b1 : ((out_vld_ff && !rsp_stall) ? 1'b0 : out_vld_ff);
      out_data_in = fire ? core_result : out_data_ff;

      range_lo_in = range_lo_ff;
      range_hi_in = range_hi_ff;
      if (csr_write) begin
         if (csr_paddr[2]) begin
            range_hi_in[csr_servo] = csr_pwdata[7:0];
         end else begin
            range_lo_in[csr_servo] = csr_pwdata[7:0];
         end
      end

      csr_prdata = {24'd0, csr_paddr[2] ? range_hi_ff[csr_servo] : range_lo_ff[csr_servo]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         range_lo_ff <= sacc_pkg::RANGE_LO_INIT;
         range_hi_ff <= sacc_pkg::RANGE_HI_INIT;
      end else begin
         in_vld_ff   <= in_vld_in;
         out_vld_ff  <= out_vld_in;
         range_lo_ff <= range_lo_in;
         range_hi_ff <= range_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   sacc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (in_data_ff),
      .range_lo (range_lo_ff),
      .range_hi (range_hi_ff),
      .result   (core_result)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
